[sv/rtc_calendar_to_epoch_ms_top_macros.svh]
// Assertion helpers for the calendar-to-epoch block.
// Both expect clk and rst_n in scope; checks are off while in reset.
`ifndef RTC_CALENDAR_TO_EPOCH_MS_TOP_MACROS_SVH
`define RTC_CALENDAR_TO_EPOCH_MS_TOP_MACROS_SVH

// same-cycle implication
`define RTC_C2E_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtc_c2e: same-cycle check failed");

// next-cycle implication
`define RTC_C2E_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtc_c2e: next-cycle check failed");

`endif

[sv/rtc_c2e_pkg.sv]
package rtc_c2e_pkg;

  typedef logic [6:0]  yr_t;
  typedef logic [3:0]  mon_t;
  typedef logic [4:0]  dom_t;
  typedef logic [4:0]  hr_t;
  typedef logic [5:0]  mnt_t;
  typedef logic [5:0]  sec_t;
  typedef logic [14:0] sub_t;
  typedef logic [41:0] ms_t;

  localparam int DAYS_W = 16;   // days since 1970, below 58k for any 7-bit year
  localparam int TOD_W  = 17;   // seconds of day, over-range fields included
  localparam int SEC_W  = 34;   // whole seconds since 1970
  localparam int MSW_W  = 44;   // whole milliseconds before saturation
  localparam int DVS_W  = 16;   // prescaler + 1
  localparam int NUM_W  = 25;   // (P - S) * 1000
  localparam int REM_W  = 26;
  localparam int QUO_W  = 10;   // fraction is always below 1000
  localparam int DIV_BITS   = 2;  // quotient bits resolved per stage
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  localparam logic [DAYS_W-1:0] DAYS_TO_2000  = 16'd10957;
  localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;
  localparam logic [6:0]        CENTURY_YR    = 7'd100;  // 2100, not a leap year
  localparam logic [3:0]        FEB           = 4'd2;
  localparam logic [16:0]       SEC_PER_DAY   = 17'd86400;
  localparam logic [11:0]       SEC_PER_HOUR  = 12'd3600;
  localparam logic [5:0]        SEC_PER_MIN   = 6'd60;
  localparam logic [9:0]        MS_PER_SEC    = 10'd1000;
  localparam logic [14:0]       PRESC_RESET   = 15'd255;
  localparam ms_t               MS_MAX        = '1;

  // days before the first of the month, non-leap; 0 and 1 add nothing,
  // above 12 adds the whole year
  function automatic logic [8:0] month_cum(input mon_t mon);
    logic [8:0] d;
    case (mon)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    return d;
  endfunction

  // leap test for 2001..2127
  function automatic logic leap_yr(input yr_t yr);
    return (yr[1:0] == 2'b00) && (yr != CENTURY_YR);
  endfunction

  // leap years in [2000, 2000 + yr)
  function automatic logic [5:0] leaps_before(input yr_t yr);
    logic [7:0] n;
    n = ({1'b0, yr} + 8'd3) >> 2;
    return 6'(n - {7'd0, (yr > CENTURY_YR)});
  endfunction

endpackage

[sv/rtc_calendar_to_epoch_ms_top.sv]
// Calendar reading to Unix epoch milliseconds. A request is taken on any
// rising edge with start high; busy is always low, so a new reading may be
// issued every cycle. Each result is presented for one cycle on out_valid;
// the receiver cannot hold it off and must capture it then. The block is an
// eight-register pipeline: day count, two multipliers, a carry-add, the
// x1000 multiply, the five-stage two-bit-per-stage fraction divider, and
// the final add with saturation. Results leave in request order. A year
// field of zero flags an unset clock and returns zero. The prescaler
// register is written through cfg_valid/cfg_ready (always ready) and should
// only change while no request is in flight.
`include "rtc_calendar_to_epoch_ms_top_macros.svh"

module rtc_calendar_to_epoch_ms_top (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                start,
  output logic                busy,
  input  rtc_c2e_pkg::yr_t    in_year_after_2000,
  input  rtc_c2e_pkg::mon_t   in_month,
  input  rtc_c2e_pkg::dom_t   in_day_of_month,
  input  rtc_c2e_pkg::hr_t    in_hours,
  input  rtc_c2e_pkg::mnt_t   in_minutes,
  input  rtc_c2e_pkg::sec_t   in_seconds,
  input  rtc_c2e_pkg::sub_t   in_subsecond_count,
  // prescaler write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rtc_c2e_pkg::sub_t   cfg_subsecond_prescaler,
  // result channel
  output logic                out_valid,
  output rtc_c2e_pkg::ms_t    out_epoch_ms,
  output logic                out_clock_unset
);
  import rtc_c2e_pkg::*;

  localparam int NSTG = 8;

  logic                   accept;
  logic [NSTG-1:0]        vld_r, vld_nxt;
  logic [NSTG-1:0]        unset_r, unset_nxt;
  sub_t                   presc_r, presc_nxt;

  // stage 1: day count, time of day, fraction operands
  logic [DAYS_W-1:0]      days_r, days_nxt;
  logic [TOD_W-1:0]       tod1_r, tod1_nxt;
  sub_t                   diff_r, diff_nxt;
  logic [DVS_W-1:0]       dvs1_r, dvs1_nxt;
  // stage 2: products
  logic [32:0]            dsec_r, dsec_nxt;
  logic [TOD_W-1:0]       tod2_r, tod2_nxt;
  logic [NUM_W-1:0]       num_r, num_nxt;
  logic [DVS_W-1:0]       dvs2_r, dvs2_nxt;
  // stage 3..7: whole-ms path
  logic [SEC_W-1:0]       secs_r, secs_nxt;
  logic [MSW_W-1:0]       msw4_r, msw4_nxt;
  logic [MSW_W-1:0]       msw5_r, msw6_r, msw7_r;
  // stage 3..7: divider
  logic [REM_W-1:0]       rem_r [DIV_STAGES];
  logic [REM_W-1:0]       rem_nxt [DIV_STAGES];
  logic [QUO_W-1:0]       quo_r [DIV_STAGES];
  logic [QUO_W-1:0]       quo_nxt [DIV_STAGES];
  logic [DVS_W-1:0]       dvs_r [DIV_STAGES];
  // stage 8: output
  ms_t                    epoch_r, epoch_nxt;

  // no back-pressure anywhere in the pipe
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign vld_nxt   = {vld_r[NSTG-2:0], accept};
  assign unset_nxt = {unset_r[NSTG-2:0], (in_year_after_2000 == '0)};

  always_comb begin
    presc_nxt = presc_r;
    if (cfg_valid && cfg_ready) begin
      presc_nxt = cfg_subsecond_prescaler;
    end
  end

  // ---- stage 1 ----
  always_comb begin
    logic [DAYS_W-1:0] ydays;
    logic [9:0]        mdays;
    sub_t              subc;
    ydays = DAYS_TO_2000 + 16'(in_year_after_2000) * 16'(DAYS_PER_YEAR)
            + 16'(leaps_before(in_year_after_2000));
    mdays = {1'b0, month_cum(in_month)}
            + 10'(leap_yr(in_year_after_2000) && (in_month > FEB));
    // day zero steps back into the previous month
    days_nxt = ydays + 16'(mdays) + 16'(in_day_of_month) - 16'd1;
    tod1_nxt = 17'(in_hours) * 17'(SEC_PER_HOUR) + 17'(in_minutes) * 17'(SEC_PER_MIN)
               + 17'(in_seconds);
    subc     = (in_subsecond_count > presc_r) ? presc_r : in_subsecond_count;
    diff_nxt = presc_r - subc;
    dvs1_nxt = {1'b0, presc_r} + 16'd1;
  end

  // ---- stage 2 ----
  assign dsec_nxt = 33'(days_r) * 33'(SEC_PER_DAY);
  assign tod2_nxt = tod1_r;
  assign num_nxt  = 25'(diff_r) * 25'(MS_PER_SEC);
  assign dvs2_nxt = dvs1_r;

  // ---- stage 3 / 4 ----
  assign secs_nxt = 34'(dsec_r) + 34'(tod2_r);
  assign msw4_nxt = 44'(secs_r) * 44'(MS_PER_SEC);

  // ---- divider: restoring, DIV_BITS quotient bits per stage ----
  always_comb begin
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [DVS_W-1:0] dvs;
    logic [REM_W-1:0] trial;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rem = REM_W'(num_r);
        quo = '0;
        dvs = dvs2_r;
      end else begin
        rem = rem_r[k-1];
        quo = quo_r[k-1];
        dvs = dvs_r[k-1];
      end
      for (int j = 0; j < DIV_BITS; j++) begin
        trial = REM_W'(dvs) << (QUO_W - 1 - k * DIV_BITS - j);
        if (rem >= trial) begin
          rem = rem - trial;
          quo[QUO_W - 1 - k * DIV_BITS - j] = 1'b1;
        end
      end
      rem_nxt[k] = rem;
      quo_nxt[k] = quo;
    end
  end

  // ---- stage 8: add fraction, saturate; zero for an unset clock ----
  always_comb begin
    logic [MSW_W:0] sum;
    sum = {1'b0, msw7_r} + (MSW_W + 1)'(quo_r[DIV_STAGES-1]);
    if (unset_r[NSTG-2]) begin
      epoch_nxt = '0;
    end else if (sum > (MSW_W + 1)'(MS_MAX)) begin
      epoch_nxt = MS_MAX;
    end else begin
      epoch_nxt = sum[41:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      presc_r <= PRESC_RESET;
    end else begin
      vld_r   <= vld_nxt;
      presc_r <= presc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unset_r <= unset_nxt;
    days_r  <= days_nxt;
    tod1_r  <= tod1_nxt;
    diff_r  <= diff_nxt;
    dvs1_r  <= dvs1_nxt;
    dsec_r  <= dsec_nxt;
    tod2_r  <= tod2_nxt;
    num_r   <= num_nxt;
    dvs2_r  <= dvs2_nxt;
    secs_r  <= secs_nxt;
    msw4_r  <= msw4_nxt;
    msw5_r  <= msw4_r;
    msw6_r  <= msw5_r;
    msw7_r  <= msw6_r;
    for (int k = 0; k < DIV_STAGES; k++) begin
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
      dvs_r[k] <= (k == 0) ? dvs2_r : dvs_r[k-1];
    end
    epoch_r <= epoch_nxt;
  end

  assign out_valid       = vld_r[NSTG-1];
  assign out_epoch_ms    = epoch_r;
  assign out_clock_unset = unset_r[NSTG-1];

  // ---- checks ----
  `RTC_C2E_ASSERT_NXT(a_req_enters, start && !busy, vld_r[0])
  `RTC_C2E_ASSERT_NXT(a_strobe_follows, vld_r[NSTG-2], out_valid)
  `RTC_C2E_ASSERT_IMP(a_unset_zero, out_valid && out_clock_unset, out_epoch_ms == '0)
  `RTC_C2E_ASSERT_IMP(a_frac_range, vld_r[NSTG-2], quo_r[DIV_STAGES-1] < MS_PER_SEC)
  `RTC_C2E_ASSERT_IMP(a_rem_range, vld_r[NSTG-2], rem_r[DIV_STAGES-1] < REM_W'(dvs_r[DIV_STAGES-1]))

endmodule

[tb/sv/rtc_calendar_to_epoch_ms_top_tb.sv]
`timescale 1ns / 1ps

module rtc_calendar_to_epoch_ms_top_tb;
  import rtc_c2e_pkg::*;

  // One calendar reading as seen on the request ports
  typedef struct packed {
    yr_t  year;
    mon_t month;
    dom_t day;
    hr_t  hours;
    mnt_t minutes;
    sec_t seconds;
    sub_t subsec;
  } rtc_reading_t;

  // One conversion result
  typedef struct packed {
    ms_t  epoch_ms;
    logic clock_unset;
  } epoch_result_t;

  // --------------------------------------------------------------------
  // Clock, reset and DUT signals; every input has a known value at time 0
  // --------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic start = 1'b0;
  logic busy;
  yr_t  in_year_after_2000 = '0;
  mon_t in_month           = '0;
  dom_t in_day_of_month    = '0;
  hr_t  in_hours           = '0;
  mnt_t in_minutes         = '0;
  sec_t in_seconds         = '0;
  sub_t in_subsecond_count = '0;

  logic cfg_valid               = 1'b0;
  logic cfg_ready;
  sub_t cfg_subsecond_prescaler = '0;

  logic out_valid;
  ms_t  out_epoch_ms;
  logic out_clock_unset;

  always #5 clk = ~clk;

  rtc_calendar_to_epoch_ms_top uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_year_after_2000      (in_year_after_2000),
    .in_month                (in_month),
    .in_day_of_month         (in_day_of_month),
    .in_hours                (in_hours),
    .in_minutes              (in_minutes),
    .in_seconds              (in_seconds),
    .in_subsecond_count      (in_subsecond_count),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_subsecond_prescaler (cfg_subsecond_prescaler),
    .out_valid               (out_valid),
    .out_epoch_ms            (out_epoch_ms),
    .out_clock_unset         (out_clock_unset)
  );

  // --------------------------------------------------------------------
  // Predictor state
  // --------------------------------------------------------------------
  sub_t          model_prescaler = PRESC_RESET;  // mirrors the prescaler register
  epoch_result_t pending_epochs[$];              // predictions, oldest first
  int unsigned   error_count = 0;
  bit            no_idle = 1'b0;                 // back-to-back requests when set

  // non-leap month lengths, indexed by month number
  int unsigned month_len_tab [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  function automatic bit is_gregorian_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Epoch milliseconds for one reading under a given prescaler.
  // Day count walks the years from 1970, then whole months (month 0 adds
  // nothing, anything past 12 adds the full year), then the day less one.
  function automatic epoch_result_t predict_epoch(input rtc_reading_t rd,
                                                  input sub_t presc);
    epoch_result_t   res;
    longint unsigned days;
    longint unsigned ms;
    int unsigned     full_year;
    sub_t            sub_clamped;
    res.epoch_ms    = '0;
    res.clock_unset = 1'b0;
    if (rd.year == '0) begin
      res.clock_unset = 1'b1;
      return res;
    end
    full_year = 2000 + rd.year;
    days = 0;
    for (int unsigned y = 1970; y < full_year; y++)
      days += is_gregorian_leap(y) ? 366 : 365;
    for (int unsigned m = 1; m < rd.month && m <= 12; m++) begin
      days += month_len_tab[m];
      if (m == 2 && is_gregorian_leap(full_year))
        days++;
    end
    // day zero means the day before the first; days is large so no wrap
    days = days + 64'(rd.day) - 1;
    ms = (days * 86400 + 64'(rd.hours) * 3600 + 64'(rd.minutes) * 60
          + 64'(rd.seconds)) * 1000;
    if (presc != '0) begin
      sub_clamped = (rd.subsec > presc) ? presc : rd.subsec;
      ms += (64'(presc - sub_clamped) * 1000) / (64'(presc) + 1);
    end
    if (ms > 64'(MS_MAX))
      ms = 64'(MS_MAX);
    res.epoch_ms = ms_t'(ms);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------
  // Monitor: tracks prescaler writes, predicts every accepted request and
  // checks each strobed result against the oldest prediction. Sampled on
  // the rising edge, so it sees the values held through the cycle before.
  // --------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    rtc_reading_t  rd;
    epoch_result_t want;
    if (!rst_n) begin
      model_prescaler = PRESC_RESET;
    end else begin
      if (out_valid) begin
        if (pending_epochs.size() == 0) begin
          report_mismatch($sformatf("result %0d/%b with no request outstanding",
                                    out_epoch_ms, out_clock_unset));
        end else begin
          want = pending_epochs.pop_front();
          if (out_epoch_ms !== want.epoch_ms)
            report_mismatch($sformatf("epoch_ms got %0d, want %0d",
                                      out_epoch_ms, want.epoch_ms));
          if (out_clock_unset !== want.clock_unset)
            report_mismatch($sformatf("clock_unset got %b, want %b",
                                      out_clock_unset, want.clock_unset));
        end
      end
      if (cfg_valid && cfg_ready)
        model_prescaler = cfg_subsecond_prescaler;
      if (start && !busy) begin
        rd = '{in_year_after_2000, in_month, in_day_of_month, in_hours,
               in_minutes, in_seconds, in_subsecond_count};
        pending_epochs.push_back(predict_epoch(rd, model_prescaler));
      end
    end
  end

  // --------------------------------------------------------------------
  // Request driver. Holds start until the request is taken, then idles for
  // a random gap: mostly none or short, now and then long. With no_idle
  // set, start stays high and the next request follows straight on.
  // --------------------------------------------------------------------
  task automatic send_reading(input yr_t yr, input mon_t mon, input dom_t day,
                              input hr_t hh, input mnt_t mm, input sec_t ss,
                              input sub_t sub);
    int unsigned gap;
    int unsigned roll;
    in_year_after_2000 <= yr;
    in_month           <= mon;
    in_day_of_month    <= day;
    in_hours           <= hh;
    in_minutes         <= mm;
    in_seconds         <= ss;
    in_subsecond_count <= sub;
    start              <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    roll = $urandom_range(99);
    if (no_idle || roll < 55)
      gap = 0;
    else if (roll < 90)
      gap = $urandom_range(3, 1);
    else
      gap = $urandom_range(24, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every outstanding request come back, then the pipeline settle.
  // Anything still missing after a generous wait is flagged and dropped.
  task automatic wait_drain;
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    while (pending_epochs.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    if (pending_epochs.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_epochs.size()));
      pending_epochs.delete();
    end
    repeat (12) @(posedge clk);
  endtask

  // Prescaler writes happen only with the pipeline empty
  task automatic write_prescaler(input sub_t value);
    wait_drain();
    cfg_subsecond_prescaler <= value;
    cfg_valid               <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------

  // Year zero: result forced to zero with the flag, whatever else is given
  task automatic test_unset_clock;
    send_reading(7'd0, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30, 15'd100);
    send_reading(7'd0, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 15'd32767);
  endtask

  // Ends of the legal calendar and the leap-year boundaries
  task automatic test_calendar_extremes;
    send_reading(7'd1,   4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  15'd255);  // no fraction
    send_reading(7'd99,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 15'd0);    // largest legal
    send_reading(7'd24,  4'd2,  5'd29, 5'd10, 6'd20, 6'd30, 15'd128);  // leap day
    send_reading(7'd24,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  15'd1);    // after leap Feb
    send_reading(7'd100, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  15'd254);  // 2100, no leap
    send_reading(7'd96,  4'd12, 5'd31, 5'd12, 6'd0,  6'd0,  15'd64);
  endtask

  // Fields outside their calendar ranges, clamping and saturation
  task automatic test_out_of_range_fields;
    send_reading(7'd23, 4'd0,  5'd10, 5'd1,  6'd2,  6'd3,  15'd7);     // month zero
    send_reading(7'd23, 4'd13, 5'd10, 5'd1,  6'd2,  6'd3,  15'd7);     // month past Dec
    send_reading(7'd23, 4'd15, 5'd10, 5'd1,  6'd2,  6'd3,  15'd7);
    send_reading(7'd50, 4'd5,  5'd0,  5'd0,  6'd0,  6'd0,  15'd0);     // day zero
    send_reading(7'd50, 4'd2,  5'd31, 5'd0,  6'd0,  6'd0,  15'd0);     // 31 Feb
    send_reading(7'd42, 4'd7,  5'd4,  5'd31, 6'd63, 6'd63, 15'd300);   // time overflow
    send_reading(7'd42, 4'd7,  5'd4,  5'd8,  6'd9,  6'd10, 15'd32767); // clamp sub
    send_reading(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 15'd0);   // saturates
    send_reading(7'd110, 4'd8,  5'd20, 5'd6,  6'd7,  6'd8,  15'd9);
  endtask

  // Prescaler off, at its top, at one, then back to the reset value
  task automatic test_prescaler_extremes;
    write_prescaler(15'd0);
    send_reading(7'd30, 4'd4, 5'd4, 5'd4, 6'd4, 6'd4, 15'd0);
    send_reading(7'd30, 4'd4, 5'd4, 5'd4, 6'd4, 6'd4, 15'd32767);
    write_prescaler(15'd32767);
    send_reading(7'd31, 4'd9, 5'd9, 5'd9, 6'd9, 6'd9, 15'd0);
    send_reading(7'd31, 4'd9, 5'd9, 5'd9, 6'd9, 6'd9, 15'd32767);
    send_reading(7'd31, 4'd9, 5'd9, 5'd9, 6'd9, 6'd9, 15'd16383);
    write_prescaler(15'd1);
    send_reading(7'd32, 4'd1, 5'd2, 5'd3, 6'd4, 6'd5, 15'd0);
    send_reading(7'd32, 4'd1, 5'd2, 5'd3, 6'd4, 6'd5, 15'd1);
    write_prescaler(PRESC_RESET);
  endtask

  // --------------------------------------------------------------------
  // Random readings over several prescaler settings. Most are proper dates
  // with a sub-second count inside the prescaler range; the rest are unset
  // clocks or fully random field values.
  // --------------------------------------------------------------------
  task automatic test_random_readings;
    sub_t        presc;
    yr_t         yr;
    mon_t        mon;
    dom_t        day;
    hr_t         hh;
    mnt_t        mm;
    sec_t        ss;
    sub_t        sub;
    int unsigned roll;
    int unsigned mlen;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       presc = PRESC_RESET;
        1:       presc = 15'd32767;
        2:       presc = 15'd0;
        3:       presc = 15'd1;
        4:       presc = sub_t'($urandom_range(15, 2));
        default: presc = sub_t'($urandom_range(32767, 0));
      endcase
      write_prescaler(presc);
      for (int n = 0; n < 128; n++) begin
        if (n % 32 == 0)
          no_idle = ($urandom_range(3) == 0);
        roll = $urandom_range(99);
        if (roll < 80) begin
          yr   = yr_t'($urandom_range(99, 1));
          mon  = mon_t'($urandom_range(12, 1));
          mlen = month_len_tab[mon];
          if (mon == 4'd2 && yr[1:0] == 2'b00)
            mlen = 29;
          day  = dom_t'($urandom_range(mlen, 1));
          hh   = hr_t'($urandom_range(23, 0));
          mm   = mnt_t'($urandom_range(59, 0));
          ss   = sec_t'($urandom_range(59, 0));
          if ($urandom_range(9) != 0)
            sub = sub_t'($urandom_range(presc, 0));
          else
            sub = sub_t'($urandom);
        end else begin
          yr  = (roll < 86) ? '0 : yr_t'($urandom);
          mon = mon_t'($urandom);
          day = dom_t'($urandom);
          hh  = hr_t'($urandom);
          mm  = mnt_t'($urandom);
          ss  = sec_t'($urandom);
          sub = sub_t'($urandom);
        end
        send_reading(yr, mon, day, hh, mm, ss, sub);
      end
      no_idle = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unset_clock();
    test_calendar_extremes();
    test_out_of_range_fields();
    test_prescaler_extremes();
    test_random_readings();

    wait_drain();
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[rtc_calendar_to_epoch_ms_top.f]
+incdir+sv
sv/rtc_c2e_pkg.sv
sv/rtc_calendar_to_epoch_ms_top.sv
tb/sv/rtc_calendar_to_epoch_ms_top_tb.sv
